// File: hdl/dmr_pkg.sv
// Shared types, register indexes, item codes and arithmetic helpers for the
// dual motor ramp PWM drive. No dependencies.
package dmr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_INTV = 3'd4;

    localparam logic [6:0]  CEILING_RST   = 7'd60;
    localparam logic [6:0]  ACCEL_RST     = 7'd5;
    localparam logic [6:0]  DECEL_RST     = 7'd10;
    localparam logic [6:0]  MIN_DRIVE_RST = 7'd25;
    localparam logic [15:0] TICK_INTV_RST = 16'd20;

    // Largest speed magnitude in percent.
    localparam logic [6:0] PCT_FULL = 7'd100;

    // mag * 255 / 100 is computed as (mag * DUTY_RECIP) >> DUTY_SHIFT.
    // For mag up to 100 the error stays below 0.006, well under the 0.05
    // gap between any exact product and the next integer.
    localparam int          DUTY_SHIFT = 19;
    localparam logic [20:0] DUTY_RECIP = 21'd1336965;

    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_TICK = 2'd1,
        MODE_STOP = 2'd2
    } t_mode;

    typedef struct packed {
        logic [6:0]  ceiling;
        logic [6:0]  accel;
        logic [6:0]  decel;
        logic [6:0]  min_drive;
        logic [15:0] tick_intv;
    } t_cfg;

    // Clamps a signed percent to plus or minus the ceiling.
    function automatic logic signed [7:0] clamp_ceiling(
        input logic signed [7:0] v,
        input logic [6:0]        ceiling
    );
        logic signed [7:0] lim;
        lim = signed'({1'b0, ceiling});
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

// File: hdl/dmr_in_if.sv
// Input channel of the dual motor ramp PWM drive: one command beat per item.
// Depends on nothing.
interface dmr_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [7:0] left_target;
    logic signed [7:0] right_target;
    logic [31:0]       now_ms;

    modport source (output valid, mode, left_target, right_target, now_ms, input ready);
    modport sink   (input valid, mode, left_target, right_target, now_ms, output ready);
endinterface

// File: hdl/dmr_out_if.sv
// Result channel of the dual motor ramp PWM drive: duties and levels per beat.
// Depends on nothing.
interface dmr_out_if;
    logic              valid;
    logic              ready;
    logic              driven;
    logic [7:0]        left_fwd_duty;
    logic [7:0]        left_rev_duty;
    logic [7:0]        right_fwd_duty;
    logic [7:0]        right_rev_duty;
    logic signed [7:0] left_level;
    logic signed [7:0] right_level;

    modport source (output valid, driven, left_fwd_duty, left_rev_duty, right_fwd_duty,
                    right_rev_duty, left_level, right_level, input ready);
    modport sink   (input valid, driven, left_fwd_duty, left_rev_duty, right_fwd_duty,
                    right_rev_duty, left_level, right_level, output ready);
endinterface

// File: hdl/dmr_cfg_regs.sv
// Configuration register bank of the dual motor ramp PWM drive.
// Depends on dmr_pkg.
module dmr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dmr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dmr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dmr_pkg::t_cfg                   o_cfg
);

    dmr_pkg::t_cfg r_cfg;
    logic [6:0]    w_v7;

    assign w_v7 = i_cfg_data[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ceiling   <= dmr_pkg::CEILING_RST;
            r_cfg.accel     <= dmr_pkg::ACCEL_RST;
            r_cfg.decel     <= dmr_pkg::DECEL_RST;
            r_cfg.min_drive <= dmr_pkg::MIN_DRIVE_RST;
            r_cfg.tick_intv <= dmr_pkg::TICK_INTV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dmr_pkg::REG_CEILING: begin
                    // A zero ceiling is refused; anything above full scale saturates.
                    if (w_v7 != 7'd0) begin
                        r_cfg.ceiling <= (w_v7 > dmr_pkg::PCT_FULL) ? dmr_pkg::PCT_FULL : w_v7;
                    end
                end
                dmr_pkg::REG_ACCEL:     r_cfg.accel     <= w_v7;
                dmr_pkg::REG_DECEL:     r_cfg.decel     <= w_v7;
                dmr_pkg::REG_MIN_DRIVE: r_cfg.min_drive <= w_v7;
                dmr_pkg::REG_TICK_INTV: r_cfg.tick_intv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/dmr_side.sv
// One side's ramp step and H-bridge duty mapping, purely combinational.
// Depends on dmr_pkg.
module dmr_side (
    input  dmr_pkg::t_cfg     i_cfg,
    input  logic signed [7:0] i_cur,
    input  logic signed [7:0] i_goal,
    output logic signed [7:0] o_level,
    output logic [7:0]        o_fwd,
    output logic [7:0]        o_rev
);

    logic signed [7:0] w_goal;
    logic [7:0]        w_goal_mag;
    logic [7:0]        w_cur_mag;
    logic signed [9:0] w_step;
    logic signed [9:0] w_diff;
    logic signed [9:0] w_moved;
    logic [6:0]        w_mag;
    logic [6:0]        w_raised;
    logic [6:0]        w_capped;
    logic [27:0]       w_prod;
    logic [7:0]        w_duty;

    always_comb begin
        // The goal is re-clamped because the ceiling may have dropped since it was set.
        w_goal     = dmr_pkg::clamp_ceiling(i_goal, i_cfg.ceiling);
        w_goal_mag = w_goal[7] ? 8'(-w_goal) : 8'(w_goal);
        w_cur_mag  = i_cur[7]  ? 8'(-i_cur)  : 8'(i_cur);
        w_step     = (w_goal_mag > w_cur_mag) ? signed'({3'b000, i_cfg.accel})
                                              : signed'({3'b000, i_cfg.decel});
        w_diff     = 10'(w_goal) - 10'(i_cur);
        w_moved    = (w_diff > 10'sd0) ? 10'(i_cur) + w_step : 10'(i_cur) - w_step;
        if (w_diff >= -w_step && w_diff <= w_step) begin
            o_level = w_goal;
        end else begin
            o_level = w_moved[7:0];
        end

        w_mag    = o_level[7] ? 7'(-o_level) : o_level[6:0];
        w_raised = (w_mag != 7'd0 && w_mag < i_cfg.min_drive) ? i_cfg.min_drive : w_mag;
        w_capped = (w_raised > i_cfg.ceiling) ? i_cfg.ceiling : w_raised;
        w_prod   = 28'(w_capped) * 28'(dmr_pkg::DUTY_RECIP);
        w_duty   = w_prod[dmr_pkg::DUTY_SHIFT +: 8];

        o_fwd = (o_level > 8'sd0) ? w_duty : 8'd0;
        o_rev = (o_level < 8'sd0) ? w_duty : 8'd0;
    end

endmodule

// File: hdl/dual_motor_ramp_pwm_drive_unit.sv
// Top level of the dual motor ramp PWM drive: command register, state, result register.
// Depends on dmr_pkg, dmr_in_if, dmr_out_if, dmr_cfg_regs and dmr_side.
//
// Usage:
//   Commands arrive as beats on i_item (valid/ready). A set-target beat stores
//   left and right goals clamped to the ceiling, a tick beat carrying now_ms
//   ramps both levels one step toward their goals when the tick interval has
//   elapsed, and a hard-stop beat zeroes goals, levels and duties.
//   Every command beat yields exactly one beat on o_result carrying the held
//   bridge duties, both levels and the driven flag.
//   A beat is captured in the command register, the ramp and duty math of both
//   sides runs combinationally between the registers, and the result is captured
//   in the result register. Throughput is one beat per cycle while results are
//   taken; the command register takes a new beat in the same cycle that its
//   current one moves on to the result register.
//   If o_result stalls, the result register holds, the one beat in the
//   command register waits behind it, and i_item.ready drops until space opens.
//   Reset (synchronous, active low) empties both registers, clears goals,
//   levels, duties and the last tick time, and loads the register defaults.
//   Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data take effect at the
//   next edge and are meant to happen only while no beat is in flight.
module dual_motor_ramp_pwm_drive_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dmr_in_if.sink                          i_item,
    dmr_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [dmr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dmr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    dmr_pkg::t_cfg w_cfg;

    // Command register.
    logic              r_s1_valid;
    logic [1:0]        r_s1_mode;
    logic signed [7:0] r_s1_left;
    logic signed [7:0] r_s1_right;
    logic [31:0]       r_s1_now;

    // Architectural state.
    logic signed [7:0] r_left_goal, n_left_goal;
    logic signed [7:0] r_right_goal, n_right_goal;
    logic signed [7:0] r_left_lvl, n_left_lvl;
    logic signed [7:0] r_right_lvl, n_right_lvl;
    logic [31:0]       r_last_tick, n_last_tick;
    logic [7:0]        r_lf_duty, n_lf_duty;
    logic [7:0]        r_lr_duty, n_lr_duty;
    logic [7:0]        r_rf_duty, n_rf_duty;
    logic [7:0]        r_rr_duty, n_rr_duty;
    logic              n_driven;

    // Result register.
    logic              r_out_valid;
    logic              r_out_driven;
    logic [7:0]        r_out_lf, r_out_lr, r_out_rf, r_out_rr;
    logic signed [7:0] r_out_left, r_out_right;

    logic              w_advance;
    logic              w_tick_due;
    logic [31:0]       w_elapsed;
    logic signed [7:0] w_left_ramp, w_right_ramp;
    logic [7:0]        w_lf, w_lr, w_rf, w_rr;

    dmr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    dmr_side u_left (
        .i_cfg   (w_cfg),
        .i_cur   (r_left_lvl),
        .i_goal  (r_left_goal),
        .o_level (w_left_ramp),
        .o_fwd   (w_lf),
        .o_rev   (w_lr)
    );

    dmr_side u_right (
        .i_cfg   (w_cfg),
        .i_cur   (r_right_lvl),
        .i_goal  (r_right_goal),
        .o_level (w_right_ramp),
        .o_fwd   (w_rf),
        .o_rev   (w_rr)
    );

    // The command in stage one moves on whenever the result register is free
    // or is being emptied in this cycle.
    assign w_advance    = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || w_advance;

    // Wrapping elapsed time since the last accepted tick.
    assign w_elapsed  = r_s1_now - r_last_tick;
    assign w_tick_due = w_elapsed >= {16'd0, w_cfg.tick_intv};

    always_comb begin
        n_left_goal  = r_left_goal;
        n_right_goal = r_right_goal;
        n_left_lvl   = r_left_lvl;
        n_right_lvl  = r_right_lvl;
        n_last_tick  = r_last_tick;
        n_lf_duty    = r_lf_duty;
        n_lr_duty    = r_lr_duty;
        n_rf_duty    = r_rf_duty;
        n_rr_duty    = r_rr_duty;
        n_driven     = 1'b0;
        case (r_s1_mode)
            dmr_pkg::MODE_SET: begin
                n_left_goal  = dmr_pkg::clamp_ceiling(r_s1_left, w_cfg.ceiling);
                n_right_goal = dmr_pkg::clamp_ceiling(r_s1_right, w_cfg.ceiling);
            end
            dmr_pkg::MODE_TICK: begin
                if (w_tick_due) begin
                    n_last_tick = r_s1_now;
                    n_left_lvl  = w_left_ramp;
                    n_right_lvl = w_right_ramp;
                    n_lf_duty   = w_lf;
                    n_lr_duty   = w_lr;
                    n_rf_duty   = w_rf;
                    n_rr_duty   = w_rr;
                    n_driven    = 1'b1;
                end
            end
            dmr_pkg::MODE_STOP: begin
                // The last tick time survives a hard stop.
                n_left_goal  = 8'sd0;
                n_right_goal = 8'sd0;
                n_left_lvl   = 8'sd0;
                n_right_lvl  = 8'sd0;
                n_lf_duty    = 8'd0;
                n_lr_duty    = 8'd0;
                n_rf_duty    = 8'd0;
                n_rr_duty    = 8'd0;
                n_driven     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_left_goal  <= 8'sd0;
            r_right_goal <= 8'sd0;
            r_left_lvl   <= 8'sd0;
            r_right_lvl  <= 8'sd0;
            r_last_tick  <= 32'd0;
            r_lf_duty    <= 8'd0;
            r_lr_duty    <= 8'd0;
            r_rf_duty    <= 8'd0;
            r_rr_duty    <= 8'd0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_left_goal  <= n_left_goal;
                r_right_goal <= n_right_goal;
                r_left_lvl   <= n_left_lvl;
                r_right_lvl  <= n_right_lvl;
                r_last_tick  <= n_last_tick;
                r_lf_duty    <= n_lf_duty;
                r_lr_duty    <= n_lr_duty;
                r_rf_duty    <= n_rf_duty;
                r_rr_duty    <= n_rr_duty;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1_mode  <= i_item.mode;
            r_s1_left  <= i_item.left_target;
            r_s1_right <= i_item.right_target;
            r_s1_now   <= i_item.now_ms;
        end
        if (w_advance) begin
            r_out_driven <= n_driven;
            r_out_lf     <= n_lf_duty;
            r_out_lr     <= n_lr_duty;
            r_out_rf     <= n_rf_duty;
            r_out_rr     <= n_rr_duty;
            r_out_left   <= n_left_lvl;
            r_out_right  <= n_right_lvl;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.driven         = r_out_driven;
    assign o_result.left_fwd_duty  = r_out_lf;
    assign o_result.left_rev_duty  = r_out_lr;
    assign o_result.right_fwd_duty = r_out_rf;
    assign o_result.right_rev_duty = r_out_rr;
    assign o_result.left_level     = r_out_left;
    assign o_result.right_level    = r_out_right;

    // A hard stop leaves a driven result with everything at zero.
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_s1_mode == dmr_pkg::MODE_STOP |=>
            r_out_driven && r_out_left == 8'sd0 && r_out_right == 8'sd0 &&
            r_lf_duty == 8'd0 && r_lr_duty == 8'd0 && r_rf_duty == 8'd0 && r_rr_duty == 8'd0)
        else $error("hard stop did not clear levels and duties");

    // Levels never leave full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_lvl >= -8'sd100 && r_left_lvl <= 8'sd100 &&
        r_right_lvl >= -8'sd100 && r_right_lvl <= 8'sd100)
        else $error("ramped level out of range");

    // Both inputs of one bridge are never driven together.
    a_bridge_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lf_duty != 8'd0 && r_lr_duty != 8'd0) &&
        !(r_rf_duty != 8'd0 && r_rr_duty != 8'd0))
        else $error("forward and reverse duty both active on one side");

    // A waiting command is kept intact until it moves on.
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_advance |=> r_s1_valid && $stable(r_s1_now) && $stable(r_s1_mode))
        else $error("waiting command was lost or changed");

    // A result that does not drive leaves the held duties untouched.
    a_undriven_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !n_driven |=> $stable(r_lf_duty) && $stable(r_lr_duty) &&
            $stable(r_rf_duty) && $stable(r_rr_duty))
        else $error("duties changed on an undriven command");

endmodule
